// ----- rtl/surface_nets_voxel_mesher_top_macros.svh -----
// ---------------------------------------------------------------------------
// Surface nets mesher assertion macros
// Clocked assertion helpers shared by the mesher RTL.
// ---------------------------------------------------------------------------
`ifndef SURFACE_NETS_VOXEL_MESHER_TOP_MACROS_SVH
`define SURFACE_NETS_VOXEL_MESHER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SNM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define SNM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);
`define SNM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define SNM_ASSERT(lbl, prop, msg)
`define SNM_ASSERT_IMP(lbl, ante, cons, msg)
`define SNM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/snm_pkg.sv -----
// ---------------------------------------------------------------------------
// Surface nets mesher package
// Request types, state codes, register indexes and cube edge tables.
// ---------------------------------------------------------------------------
package snm_pkg;

    localparam int GRID_X_DEF = 64;
    localparam int GRID_Y_DEF = 64;
    localparam int GRID_Z_DEF = 64;

    localparam int NUM_EDGES = 12;
    localparam int NUM_NB    = 9;
    localparam int NUM_SLOTS = 7;

    localparam logic [30:0] CELL_RESET = 31'd65536;

    typedef enum logic [1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_ORIGIN_Z = 2'd2,
        CFG_CELL     = 2'd3
    } t_cfg_idx;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRI    = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE,
        ST_DIV,
        ST_MEAN,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_PLACE,
        ST_WRITE,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [5:0]         voxel_x;
        logic [5:0]         voxel_y;
        logic [5:0]         voxel_z;
        logic signed [15:0] corner_0;
        logic signed [15:0] corner_1;
        logic signed [15:0] corner_2;
        logic signed [15:0] corner_3;
        logic signed [15:0] corner_4;
        logic signed [15:0] corner_5;
        logic signed [15:0] corner_6;
        logic signed [15:0] corner_7;
    } t_in;

    typedef struct packed {
        logic               item_kind;
        logic [17:0]        vertex_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [17:0]        tri_a;
        logic [17:0]        tri_b;
        logic [17:0]        tri_c;
        logic               last_of_voxel;
    } t_out;

    localparam logic [2:0] EDGE_LO [NUM_EDGES] = '{
        3'd0, 3'd2, 3'd4, 3'd6,
        3'd0, 3'd1, 3'd4, 3'd5,
        3'd0, 3'd1, 3'd2, 3'd3
    };
    localparam logic [2:0] EDGE_HI [NUM_EDGES] = '{
        3'd1, 3'd3, 3'd5, 3'd7,
        3'd2, 3'd3, 3'd6, 3'd7,
        3'd4, 3'd5, 3'd6, 3'd7
    };
    localparam logic [1:0] EDGE_AXIS [NUM_EDGES] = '{
        2'd0, 2'd0, 2'd0, 2'd0,
        2'd1, 2'd1, 2'd1, 2'd1,
        2'd2, 2'd2, 2'd2, 2'd2
    };

    function automatic logic [1:0] nb_axis(input logic [3:0] i);
        logic [1:0] d;
        unique case (i)
            4'd0, 4'd1, 4'd2: d = 2'd0;
            4'd3, 4'd4, 4'd5: d = 2'd1;
            default:          d = 2'd2;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] nb_pos(input logic [3:0] i);
        logic [1:0] j;
        unique case (i)
            4'd0, 4'd3, 4'd6: j = 2'd0;
            4'd1, 4'd4, 4'd7: j = 2'd1;
            default:          j = 2'd2;
        endcase
        return j;
    endfunction

endpackage

// ----- rtl/surface_nets_voxel_mesher_top.sv -----
// ---------------------------------------------------------------------------
// Surface nets voxel mesher
// Places one vertex per sign-changing voxel and joins neighbor vertices
// into triangle pairs, using a two-slice vertex index map in RAM.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// in        sink       i_in_valid / o_in_ready      i_in  (snm_pkg::t_in)
// out       source     o_out_valid / i_out_ready    o_out (snm_pkg::t_out)
// cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A voxel outside the grid is accepted and dropped. An in-grid voxel runs the edge
// scan and one division of the shared serial divider per crossing edge; with a
// vertex it adds the three mean divisions, the split multiplies, the
// neighbor map reads and the push of each record (1 to 7), which output stalls can hold.
// After reset the whole map is cleared; in stays low.
// A finished record waits in the output register while the next is built.
// ---------------------------------------------------------------------------
`include "surface_nets_voxel_mesher_top_macros.svh"

module surface_nets_voxel_mesher_top #(
    parameter int GRID_X = snm_pkg::GRID_X_DEF,
    parameter int GRID_Y = snm_pkg::GRID_Y_DEF,
    parameter int GRID_Z = snm_pkg::GRID_Z_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  snm_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output snm_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    localparam int DEPTH = 2 * GRID_X * GRID_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] map_addr(input logic [5:0] x, input logic [5:0] y,
                                               input logic zp);
        return AW'(x) + AW'(GRID_X) * (AW'(y) + AW'(GRID_Y) * AW'(zp));
    endfunction

    snm_pkg::t_state r_state, n_state;

    logic [AW-1:0]      r_clr, n_clr;
    logic [5:0]         r_vx, n_vx, r_vy, n_vy, r_vz, n_vz;
    logic [3:0]         r_neg, n_neg;
    logic [15:0]        r_ea [snm_pkg::NUM_EDGES];
    logic [15:0]        n_ea [snm_pkg::NUM_EDGES];
    logic [15:0]        r_eb [snm_pkg::NUM_EDGES];
    logic [15:0]        n_eb [snm_pkg::NUM_EDGES];
    logic [snm_pkg::NUM_EDGES-1:0] r_ex, n_ex;
    logic [3:0]         r_edge, n_edge;
    logic [3:0]         r_ncross, n_ncross;
    logic [19:0]        r_sum [3];
    logic [19:0]        n_sum [3];
    logic [16:0]        r_rem, n_rem;
    logic [31:0]        r_quo, n_quo;
    logic [16:0]        r_div, n_div;
    logic [4:0]         r_step, n_step;
    logic               r_mean, n_mean;
    logic [1:0]         r_axis, n_axis;
    logic [16:0]        r_local [3];
    logic [16:0]        n_local [3];
    logic [38:0]        r_plo, n_plo;
    logic [37:0]        r_phi, n_phi;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] n_pos [3];
    logic [18:0]        r_cnt, n_cnt;
    logic [17:0]        r_self, n_self;
    logic [3:0]         r_rd, n_rd;
    logic [18:0]        r_nb [snm_pkg::NUM_NB];
    logic [18:0]        n_nb [snm_pkg::NUM_NB];
    logic [2:0]         r_slot, n_slot;
    logic               r_out_valid, n_out_valid;
    snm_pkg::t_out      r_out, n_out;
    logic signed [31:0] r_org_x, n_org_x, r_org_y, n_org_y, r_org_z, n_org_z;
    logic [30:0]        r_cell, n_cell;

    logic               in_acc;
    logic               in_grid;
    logic               out_free;
    logic               push;
    logic signed [15:0] c_in [8];
    logic [17:0]        rem_sh;
    logic               q_bit;
    logic [31:0]        quo_nx;
    logic [16:0]        rem_nx;
    logic [5:0]         coord_sel;
    logic signed [31:0] org_sel;
    logic [22:0]        val;
    logic [38:0]        off;
    logic signed [40:0] psum;
    logic signed [31:0] psat;
    logic [1:0]         nb_d;
    logic [1:0]         nb_j;
    logic [5:0]         nx, ny, nz;
    logic               dec_u, dec_v;
    logic [2:0]         ok;
    logic [2:0]         negd;
    logic [2:0]         cuv;
    logic [snm_pkg::NUM_SLOTS-1:0] en;
    snm_pkg::t_out      rec [snm_pkg::NUM_SLOTS];
    logic               rec_last;
    logic [2:0]         slot_nxt;
    logic [17:0]        e1, e2, e3;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [18:0]        ram_wdata, ram_rdata;

    snm_ram #(
        .WIDTH (19),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_acc   = i_in_valid && o_in_ready;
    assign in_grid  = (11'(i_in.voxel_x) < 11'(GRID_X)) && (11'(i_in.voxel_y) < 11'(GRID_Y))
                   && (11'(i_in.voxel_z) < 11'(GRID_Z));
    assign out_free = !r_out_valid || i_out_ready;

    assign c_in[0] = i_in.corner_0;
    assign c_in[1] = i_in.corner_1;
    assign c_in[2] = i_in.corner_2;
    assign c_in[3] = i_in.corner_3;
    assign c_in[4] = i_in.corner_4;
    assign c_in[5] = i_in.corner_5;
    assign c_in[6] = i_in.corner_6;
    assign c_in[7] = i_in.corner_7;

    // serial restoring divider step
    always_comb begin
        rem_sh = {r_rem, r_quo[31]};
        q_bit  = rem_sh >= {1'b0, r_div};
        rem_nx = q_bit ? 17'(rem_sh - {1'b0, r_div}) : 17'(rem_sh);
        quo_nx = {r_quo[30:0], q_bit};
    end

    // placement arithmetic
    always_comb begin
        unique case (r_axis)
            2'd0:    begin coord_sel = r_vx; org_sel = r_org_x; end
            2'd1:    begin coord_sel = r_vy; org_sel = r_org_y; end
            default: begin coord_sel = r_vz; org_sel = r_org_z; end
        endcase
        val  = 23'({coord_sel, 16'b0}) + 23'(r_local[r_axis]);
        off  = 39'(r_phi) + 39'(r_plo[38:16]);
        psum = $signed({2'b00, off}) + $signed({{9{org_sel[31]}}, org_sel});
        if (psum > 41'sd2147483647) begin
            psat = 32'sh7FFFFFFF;
        end else if (psum < -41'sd2147483648) begin
            psat = 32'sh80000000;
        end else begin
            psat = psum[31:0];
        end
    end

    // neighbor address
    always_comb begin
        nb_d  = snm_pkg::nb_axis(r_rd);
        nb_j  = snm_pkg::nb_pos(r_rd);
        dec_u = (nb_j != 2'd2);
        dec_v = (nb_j != 2'd0);
        nx = r_vx;
        ny = r_vy;
        nz = r_vz;
        unique case (nb_d)
            2'd0:    begin ny = r_vy - 6'(dec_u); nz = r_vz - 6'(dec_v); end
            2'd1:    begin nz = r_vz - 6'(dec_u); nx = r_vx - 6'(dec_v); end
            default: begin nx = r_vx - 6'(dec_u); ny = r_vy - 6'(dec_v); end
        endcase
    end

    // record assembly
    always_comb begin
        negd = r_neg[3:1];
        cuv[0] = (r_vy != 6'd0) && (r_vz != 6'd0);
        cuv[1] = (r_vz != 6'd0) && (r_vx != 6'd0);
        cuv[2] = (r_vx != 6'd0) && (r_vy != 6'd0);
        rec[0] = '0;
        rec[0].item_kind    = snm_pkg::KIND_VERTEX;
        rec[0].vertex_index = r_self;
        rec[0].pos_x        = r_pos[0];
        rec[0].pos_y        = r_pos[1];
        rec[0].pos_z        = r_pos[2];
        en[0] = 1'b1;
        for (int d = 0; d < 3; d++) begin
            ok[d] = cuv[d] && (r_neg[0] != negd[d]) && r_nb[3*d][18] && r_nb[3*d+1][18]
                 && r_nb[3*d+2][18];
            e1 = r_nb[3*d][17:0];
            e2 = r_nb[3*d+1][17:0];
            e3 = r_nb[3*d+2][17:0];
            rec[2*d+1] = '0;
            rec[2*d+2] = '0;
            rec[2*d+1].item_kind = snm_pkg::KIND_TRI;
            rec[2*d+2].item_kind = snm_pkg::KIND_TRI;
            rec[2*d+1].tri_a = r_self;
            rec[2*d+2].tri_a = r_self;
            rec[2*d+1].tri_c = e2;
            rec[2*d+2].tri_b = e2;
            rec[2*d+1].tri_b = r_neg[0] ? e1 : e3;
            rec[2*d+2].tri_c = r_neg[0] ? e3 : e1;
            en[2*d+1] = ok[d];
            en[2*d+2] = ok[d];
        end
        slot_nxt = r_slot;
        rec_last = 1'b1;
        for (int s = snm_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
            if (en[s] && (3'(s) > r_slot)) begin
                slot_nxt = 3'(s);
                rec_last = 1'b0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            snm_pkg::ST_CLEAR: if (r_clr == CLR_LAST) n_state = snm_pkg::ST_IDLE;
            snm_pkg::ST_IDLE:  if (in_acc && in_grid) n_state = snm_pkg::ST_EDGE;
            snm_pkg::ST_EDGE: begin
                if (r_edge == 4'(snm_pkg::NUM_EDGES)) begin
                    n_state = (r_ncross == 4'd0) ? snm_pkg::ST_WRITE : snm_pkg::ST_MEAN;
                end else if (r_ex[0]) begin
                    n_state = snm_pkg::ST_DIV;
                end
            end
            snm_pkg::ST_DIV: begin
                if (r_step == 5'd31) begin
                    if (!r_mean) begin
                        n_state = snm_pkg::ST_EDGE;
                    end else begin
                        n_state = (r_axis == 2'd2) ? snm_pkg::ST_MUL_LO : snm_pkg::ST_MEAN;
                    end
                end
            end
            snm_pkg::ST_MEAN:   n_state = snm_pkg::ST_DIV;
            snm_pkg::ST_MUL_LO: n_state = snm_pkg::ST_MUL_HI;
            snm_pkg::ST_MUL_HI: n_state = snm_pkg::ST_PLACE;
            snm_pkg::ST_PLACE:
                n_state = (r_axis == 2'd2) ? snm_pkg::ST_WRITE : snm_pkg::ST_MUL_LO;
            snm_pkg::ST_WRITE:
                n_state = (r_ncross != 4'd0) ? snm_pkg::ST_READ : snm_pkg::ST_IDLE;
            snm_pkg::ST_READ:
                if (r_rd == 4'(snm_pkg::NUM_NB)) n_state = snm_pkg::ST_EMIT;
            snm_pkg::ST_EMIT:
                if (out_free && rec_last) n_state = snm_pkg::ST_IDLE;
            default: n_state = snm_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready = (r_state == snm_pkg::ST_IDLE);
        ram_we     = (r_state == snm_pkg::ST_CLEAR) || (r_state == snm_pkg::ST_WRITE);
        ram_waddr  = (r_state == snm_pkg::ST_CLEAR) ? r_clr : map_addr(r_vx, r_vy, r_vz[0]);
        ram_wdata  = (r_state == snm_pkg::ST_CLEAR) ? 19'd0
                   : {r_ncross != 4'd0, r_cnt[17:0]};
        ram_re     = (r_state == snm_pkg::ST_READ) && (r_rd != 4'(snm_pkg::NUM_NB));
        ram_raddr  = map_addr(nx, ny, nz[0]);
        push       = (r_state == snm_pkg::ST_EMIT) && out_free;
    end

    // datapath
    always_comb begin
        n_clr = r_clr;
        n_vx = r_vx;
        n_vy = r_vy;
        n_vz = r_vz;
        n_neg = r_neg;
        n_ea = r_ea;
        n_eb = r_eb;
        n_ex = r_ex;
        n_edge = r_edge;
        n_ncross = r_ncross;
        n_sum = r_sum;
        n_rem = r_rem;
        n_quo = r_quo;
        n_div = r_div;
        n_step = r_step;
        n_mean = r_mean;
        n_axis = r_axis;
        n_local = r_local;
        n_plo = r_plo;
        n_phi = r_phi;
        n_pos = r_pos;
        n_cnt = r_cnt;
        n_self = r_self;
        n_rd = r_rd;
        n_nb = r_nb;
        n_slot = r_slot;
        n_org_x = r_org_x;
        n_org_y = r_org_y;
        n_org_z = r_org_z;
        n_cell = r_cell;
        unique case (r_state)
            snm_pkg::ST_CLEAR: n_clr = r_clr + AW'(1);
            snm_pkg::ST_IDLE: begin
                if (in_acc && in_grid) begin
                    n_vx = i_in.voxel_x;
                    n_vy = i_in.voxel_y;
                    n_vz = i_in.voxel_z;
                    n_neg = {c_in[4][15], c_in[2][15], c_in[1][15], c_in[0][15]};
                    for (int e = 0; e < snm_pkg::NUM_EDGES; e++) begin
                        n_ea[e] = c_in[snm_pkg::EDGE_LO[e]][15]
                                ? 16'(~c_in[snm_pkg::EDGE_LO[e]] + 16'd1)
                                : 16'(c_in[snm_pkg::EDGE_LO[e]]);
                        n_eb[e] = c_in[snm_pkg::EDGE_HI[e]][15]
                                ? 16'(~c_in[snm_pkg::EDGE_HI[e]] + 16'd1)
                                : 16'(c_in[snm_pkg::EDGE_HI[e]]);
                        n_ex[e] = c_in[snm_pkg::EDGE_LO[e]][15]
                                ^ c_in[snm_pkg::EDGE_HI[e]][15];
                    end
                    n_edge = '0;
                    n_ncross = '0;
                    for (int j = 0; j < 3; j++) n_sum[j] = '0;
                    n_axis = '0;
                    n_slot = '0;
                    if ((i_in.voxel_x == 6'd0) && (i_in.voxel_y == 6'd0)
                            && (i_in.voxel_z == 6'd0)) begin
                        n_cnt = '0;
                    end
                end
            end
            snm_pkg::ST_EDGE: begin
                if (r_edge != 4'(snm_pkg::NUM_EDGES)) begin
                    if (r_ex[0]) begin
                        n_rem  = '0;
                        n_quo  = {r_ea[0], 16'b0};
                        n_div  = 17'(r_ea[0]) + 17'(r_eb[0]);
                        n_step = '0;
                        n_mean = 1'b0;
                    end else begin
                        for (int e = 0; e < snm_pkg::NUM_EDGES - 1; e++) begin
                            n_ea[e] = r_ea[e+1];
                            n_eb[e] = r_eb[e+1];
                        end
                        n_ex   = r_ex >> 1;
                        n_edge = r_edge + 4'd1;
                    end
                end
            end
            snm_pkg::ST_DIV: begin
                n_rem  = rem_nx;
                n_quo  = quo_nx;
                n_step = r_step + 5'd1;
                if (r_step == 5'd31) begin
                    if (r_mean) begin
                        n_local[r_axis] = quo_nx[16:0];
                        n_axis = (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                    end else begin
                        for (int j = 0; j < 3; j++) begin
                            if (snm_pkg::EDGE_AXIS[r_edge] == 2'(j)) begin
                                n_sum[j] = r_sum[j] + 20'(quo_nx[16:0]);
                            end else if (snm_pkg::EDGE_LO[r_edge][j]) begin
                                n_sum[j] = r_sum[j] + 20'h10000;
                            end
                        end
                        n_ncross = r_ncross + 4'd1;
                        for (int e = 0; e < snm_pkg::NUM_EDGES - 1; e++) begin
                            n_ea[e] = r_ea[e+1];
                            n_eb[e] = r_eb[e+1];
                        end
                        n_ex   = r_ex >> 1;
                        n_edge = r_edge + 4'd1;
                    end
                end
            end
            snm_pkg::ST_MEAN: begin
                n_rem  = '0;
                n_quo  = 32'(r_sum[r_axis]);
                n_div  = 17'(r_ncross);
                n_step = '0;
                n_mean = 1'b1;
            end
            snm_pkg::ST_MUL_LO: n_plo = 39'(val) * 39'(r_cell[15:0]);
            snm_pkg::ST_MUL_HI: n_phi = 38'(val) * 38'(r_cell[30:16]);
            snm_pkg::ST_PLACE: begin
                n_pos[r_axis] = psat;
                n_axis = (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
            end
            snm_pkg::ST_WRITE: begin
                n_self = r_cnt[17:0];
                n_rd   = '0;
                if (r_ncross != 4'd0) n_cnt = r_cnt + 19'd1;
            end
            snm_pkg::ST_READ: begin
                if (r_rd != 4'd0) n_nb[4'(r_rd - 4'd1)] = ram_rdata;
                n_rd = r_rd + 4'd1;
            end
            snm_pkg::ST_EMIT: if (out_free) n_slot = slot_nxt;
            default: ;
        endcase
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (snm_pkg::t_cfg_idx'(i_cfg_index))
                snm_pkg::CFG_ORIGIN_X: n_org_x = $signed(i_cfg_data);
                snm_pkg::CFG_ORIGIN_Y: n_org_y = $signed(i_cfg_data);
                snm_pkg::CFG_ORIGIN_Z: n_org_z = $signed(i_cfg_data);
                snm_pkg::CFG_CELL:     n_cell  = i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out = r_out;
        if (push) begin
            n_out_valid = 1'b1;
            n_out = rec[r_slot];
            n_out.last_of_voxel = rec_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= snm_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_ncross    <= '0;
            r_out_valid <= 1'b0;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_org_z     <= '0;
            r_cell      <= snm_pkg::CELL_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cnt       <= n_cnt;
            r_ncross    <= n_ncross;
            r_out_valid <= n_out_valid;
            r_org_x     <= n_org_x;
            r_org_y     <= n_org_y;
            r_org_z     <= n_org_z;
            r_cell      <= n_cell;
        end
        r_vx    <= n_vx;
        r_vy    <= n_vy;
        r_vz    <= n_vz;
        r_neg   <= n_neg;
        r_ea    <= n_ea;
        r_eb    <= n_eb;
        r_ex    <= n_ex;
        r_edge  <= n_edge;
        r_sum   <= n_sum;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_div   <= n_div;
        r_step  <= n_step;
        r_mean  <= n_mean;
        r_axis  <= n_axis;
        r_local <= n_local;
        r_plo   <= n_plo;
        r_phi   <= n_phi;
        r_pos   <= n_pos;
        r_self  <= n_self;
        r_rd    <= n_rd;
        r_nb    <= n_nb;
        r_slot  <= n_slot;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    `SNM_ASSERT(a_ncross_max, r_ncross <= 4'd12, "crossing count above twelve")
    `SNM_ASSERT_IMP(a_div_rem, r_state == snm_pkg::ST_DIV, r_rem < r_div,
        "divider remainder not below divisor")
    `SNM_ASSERT_IMP(a_emit_slot, r_state == snm_pkg::ST_EMIT, en[r_slot],
        "emitting a disabled record slot")
    `SNM_ASSERT_NXT(a_last_idle, push && rec_last, r_state == snm_pkg::ST_IDLE,
        "last record did not return to idle")

endmodule

// ----- rtl/snm_ram.sv -----
// ---------------------------------------------------------------------------
// Surface nets mesher RAM
// Simple dual-port RAM, one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module snm_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 8192,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sim/surface_nets_voxel_mesher_top_test.sv -----
// ---------------------------------------------------------------------------
// Surface nets voxel mesher testbench
// Streams voxel requests into the mesher and checks every vertex and
// triangle record against an in-bench model of vertex placement and the
// two-slice vertex map. Starts with a short directed table, then random
// raster-ordered blocks built from sample lattices, mixed with stray voxels.
// Runs over several origin and cell size settings, with random stalls on
// both channels.
// ---------------------------------------------------------------------------
module surface_nets_voxel_mesher_top_test;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int SETTLE_CYCLES = 600;
    localparam int MAP_SIZE = 2 * snm_pkg::GRID_X_DEF * snm_pkg::GRID_Y_DEF;
    localparam int RANDOM_ITEMS = 330;

    typedef struct {
        snm_pkg::t_in v;
        bit           quiet;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    snm_pkg::t_in  i_in = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    snm_pkg::t_out o_out;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index = '0;
    logic [31:0]   i_cfg_data = '0;

    surface_nets_voxel_mesher_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    longint          org_x, org_y, org_z;
    longint unsigned cell_len;
    logic [18:0]     vertex_map [MAP_SIZE];
    logic [18:0]     vertex_count;
    snm_pkg::t_out   pending_records [$];
    int              err_cnt;
    int              cycle_cnt;
    bit              steady;
    bit              cur_quiet;
    int              rdy_hold;
    logic signed [15:0] lattice [5][5][5];
    t_row            rows [$];

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    function automatic logic [31:0] place(input longint org, input int unsigned coord,
                                          input longint unsigned lcl);
        longint unsigned off;
        longint          p;
        off = ((longint'(coord) << 16) + lcl) * cell_len >> 16;
        p = org + longint'(off);
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        return p[31:0];
    endfunction

    function automatic int map_addr(input int unsigned x, input int unsigned y,
                                    input int unsigned z);
        return x + snm_pkg::GRID_X_DEF * (y + snm_pkg::GRID_Y_DEF * (z & 1));
    endfunction

    function automatic int mesh_voxel(input snm_pkg::t_in v);
        logic signed [15:0] s [8];
        int unsigned        cc [3];
        int unsigned        pu [3], pv [3], puv [3];
        int unsigned        mask, n, hi, u, w;
        longint unsigned    sum [3], na, nb, t;
        logic [18:0]        self_idx, e1, e2, e3;
        bit                 has, neg0, neg1;
        snm_pkg::t_out      recs [$];
        snm_pkg::t_out      rec;
        int                 d, a, k, j;
        s = '{v.corner_0, v.corner_1, v.corner_2, v.corner_3,
              v.corner_4, v.corner_5, v.corner_6, v.corner_7};
        cc = '{v.voxel_x, v.voxel_y, v.voxel_z};
        mask = 0;
        n = 0;
        sum = '{0, 0, 0};
        has = 0;
        self_idx = '0;
        for (k = 0; k < 8; k++) if (s[k] < 0) mask |= 1 << k;
        if (cc[0] == 0 && cc[1] == 0 && cc[2] == 0) vertex_count = '0;
        if (mask != 0 && mask != 8'hFF) begin
            for (a = 0; a < 3; a++) begin
                for (k = 0; k < 8; k++) begin
                    if (k & (1 << a)) continue;
                    hi = k | (1 << a);
                    if (((mask >> k) & 1) == ((mask >> hi) & 1)) continue;
                    na = s[k] < 0 ? -longint'(s[k]) : longint'(s[k]);
                    nb = s[hi] < 0 ? -longint'(s[hi]) : longint'(s[hi]);
                    t = (na << 16) / (na + nb);
                    for (j = 0; j < 3; j++) begin
                        if (j == a) sum[j] += t;
                        else if (k & (1 << j)) sum[j] += 65536;
                    end
                    n++;
                end
            end
            self_idx = {1'b0, vertex_count[17:0]};
            has = 1;
            vertex_count = vertex_count + 1'b1;
            rec = '0;
            rec.item_kind = snm_pkg::KIND_VERTEX;
            rec.vertex_index = self_idx[17:0];
            rec.pos_x = place(org_x, cc[0], sum[0] / n);
            rec.pos_y = place(org_y, cc[1], sum[1] / n);
            rec.pos_z = place(org_z, cc[2], sum[2] / n);
            recs.insert(recs.size(), rec);
        end
        vertex_map[map_addr(cc[0], cc[1], cc[2])] = has ? {1'b1, self_idx[17:0]} : '0;
        for (d = 0; d < 3 && has; d++) begin
            u = (d + 1) % 3;
            w = (d + 2) % 3;
            neg0 = s[0] < 0;
            neg1 = s[1 << d] < 0;
            if (cc[u] < 1 || cc[w] < 1 || neg0 == neg1) continue;
            pu = cc;
            pv = cc;
            puv = cc;
            pu[u] -= 1;
            pv[w] -= 1;
            puv[u] -= 1;
            puv[w] -= 1;
            e1 = vertex_map[map_addr(pu[0], pu[1], pu[2])];
            e2 = vertex_map[map_addr(puv[0], puv[1], puv[2])];
            e3 = vertex_map[map_addr(pv[0], pv[1], pv[2])];
            if (!e1[18] || !e2[18] || !e3[18]) continue;
            rec = '0;
            rec.item_kind = snm_pkg::KIND_TRI;
            rec.tri_a = self_idx[17:0];
            rec.tri_b = neg0 ? e1[17:0] : e3[17:0];
            rec.tri_c = e2[17:0];
            recs.insert(recs.size(), rec);
            rec.tri_b = e2[17:0];
            rec.tri_c = neg0 ? e3[17:0] : e1[17:0];
            recs.insert(recs.size(), rec);
        end
        if (recs.size() > 0) recs[recs.size() - 1].last_of_voxel = 1'b1;
        foreach (recs[i]) pending_records.insert(pending_records.size(), recs[i]);
        return recs.size();
    endfunction

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        snm_pkg::t_out want;
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            note_mismatch("cycle limit reached");
            $display("surface_nets_voxel_mesher_top test failed");
            $finish;
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            if (mesh_voxel(i_in) != 0 && cur_quiet) note_mismatch("quiet voxel made records");
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_records.size() == 0) begin
                note_mismatch("record with none expected");
            end else begin
                want = pending_records.pop_front();
                check_field("item_kind", o_out.item_kind, want.item_kind);
                check_field("vertex_index", o_out.vertex_index, want.vertex_index);
                check_field("pos_x", o_out.pos_x, want.pos_x);
                check_field("pos_y", o_out.pos_y, want.pos_y);
                check_field("pos_z", o_out.pos_z, want.pos_z);
                check_field("tri_a", o_out.tri_a, want.tri_a);
                check_field("tri_b", o_out.tri_b, want.tri_b);
                check_field("tri_c", o_out.tri_c, want.tri_c);
                check_field("last_of_voxel", o_out.last_of_voxel, want.last_of_voxel);
            end
        end
    end

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic int gap_len();
        if (steady || $urandom_range(0, 99) < 50) return 0;
        return stall_len();
    endfunction

    always @(posedge i_clk) begin
        bit rdy;
        if (rdy_hold > 0) begin
            rdy_hold--;
        end else if (steady) begin
            i_out_ready <= 1'b1;
        end else begin
            rdy = $urandom_range(0, 99) < 65;
            i_out_ready <= rdy;
            rdy_hold = rdy ? $urandom_range(0, 10) : stall_len();
        end
    end

    task automatic send(input snm_pkg::t_in v, input bit quiet);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= v;
        cur_quiet <= quiet;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic cfg_write(input snm_pkg::t_cfg_idx idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            snm_pkg::CFG_ORIGIN_X: org_x = longint'(signed'(data));
            snm_pkg::CFG_ORIGIN_Y: org_y = longint'(signed'(data));
            snm_pkg::CFG_ORIGIN_Z: org_z = longint'(signed'(data));
            snm_pkg::CFG_CELL:     cell_len = data[30:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic snm_pkg::t_in lattice_voxel(input int bx, input int by, input int bz,
                                                   input int x, input int y, input int z);
        snm_pkg::t_in v;
        v.voxel_x = 6'(bx + x);
        v.voxel_y = 6'(by + y);
        v.voxel_z = 6'(bz + z);
        v.corner_0 = lattice[x][y][z];
        v.corner_1 = lattice[x + 1][y][z];
        v.corner_2 = lattice[x][y + 1][z];
        v.corner_3 = lattice[x + 1][y + 1][z];
        v.corner_4 = lattice[x][y][z + 1];
        v.corner_5 = lattice[x + 1][y][z + 1];
        v.corner_6 = lattice[x][y + 1][z + 1];
        v.corner_7 = lattice[x + 1][y + 1][z + 1];
        return v;
    endfunction

    function automatic snm_pkg::t_in noise_voxel();
        snm_pkg::t_in v;
        logic [159:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        v = bits[$bits(snm_pkg::t_in)-1:0];
        return v;
    endfunction

    task automatic fill_lattice();
        int wx, wy, wz, thr, r, mag;
        wx = $urandom_range(0, 6) - 3;
        wy = $urandom_range(0, 6) - 3;
        wz = $urandom_range(0, 6) - 3;
        thr = $urandom_range(0, 8) - 4;
        for (int x = 0; x < 5; x++)
            for (int y = 0; y < 5; y++)
                for (int z = 0; z < 5; z++) begin
                    r = $urandom_range(0, 99);
                    mag = r < 10 ? 32767 : r < 20 ? 0 : r < 50 ? $urandom_range(1, 50)
                                                              : $urandom_range(1, 32767);
                    if (r >= 90) lattice[x][y][z] = 16'($urandom);
                    else if (wx * x + wy * y + wz * z > thr) lattice[x][y][z] = 16'(mag);
                    else lattice[x][y][z] = (r < 10) ? -16'sd32768 : 16'(-mag - 1);
                end
    endtask

    task automatic random_phase(input int items);
        int sent, nx, ny, nz, bx, by, bz;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 99) < 75) begin
                fill_lattice();
                nx = $urandom_range(2, 4);
                ny = $urandom_range(2, 4);
                nz = $urandom_range(2, 4);
                if ($urandom_range(0, 2) == 0) begin
                    bx = 0;
                    by = 0;
                    bz = 0;
                end else begin
                    bx = $urandom_range(0, 64 - nx);
                    by = $urandom_range(0, 64 - ny);
                    bz = $urandom_range(0, 64 - nz);
                end
                for (int z = 0; z < nz; z++)
                    for (int y = 0; y < ny; y++)
                        for (int x = 0; x < nx; x++)
                            send(lattice_voxel(bx, by, bz, x, y, z), 1'b0);
                sent += nx * ny * nz;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send(noise_voxel(), 1'b0);
                    sent++;
                end
            end
            if ($urandom_range(0, 9) == 0) steady = ~steady;
        end
    endtask

    function automatic snm_pkg::t_in flat_voxel(input int x, input int y, input int z,
                                                input logic signed [15:0] val);
        snm_pkg::t_in v;
        v.voxel_x = 6'(x);
        v.voxel_y = 6'(y);
        v.voxel_z = 6'(z);
        {v.corner_0, v.corner_1, v.corner_2, v.corner_3,
         v.corner_4, v.corner_5, v.corner_6, v.corner_7} = {8{val}};
        return v;
    endfunction

    initial begin
        snm_pkg::t_in v;
        logic [127:0] corners;
        org_x = 0;
        org_y = 0;
        org_z = 0;
        cell_len = snm_pkg::CELL_RESET;
        vertex_count = '0;
        foreach (vertex_map[i]) vertex_map[i] = '0;
        err_cnt = 0;
        cycle_cnt = 0;
        steady = 0;
        cur_quiet = 0;
        rdy_hold = 0;

        rows.insert(rows.size(), '{flat_voxel(0, 0, 0, 16'sd0), 1'b1});
        rows.insert(rows.size(), '{flat_voxel(0, 0, 0, -16'sd32768), 1'b1});
        rows.insert(rows.size(), '{flat_voxel(63, 63, 63, 16'sd32767), 1'b1});
        foreach (lattice[x, y, z]) lattice[x][y][z] = 16'sd200;
        lattice[1][1][1] = -16'sd100;
        for (int z = 0; z < 2; z++)
            for (int y = 0; y < 2; y++)
                for (int x = 0; x < 2; x++)
                    rows.insert(rows.size(), '{lattice_voxel(0, 0, 0, x, y, z), 1'b0});
        for (int k = 0; k < 8; k++) begin
            corners = {8{16'sd32767}};
            corners[16 * (7 - k) +: 16] = -16'sd32768;
            v = flat_voxel(k * 9, 63 - k * 9, (k & 1) ? 63 : 0, 16'sd0);
            {v.corner_0, v.corner_1, v.corner_2, v.corner_3,
             v.corner_4, v.corner_5, v.corner_6, v.corner_7} = corners;
            rows.insert(rows.size(), '{v, 1'b0});
        end
        v = flat_voxel(63, 63, 63, -16'sd1);
        v.corner_7 = 16'sd0;
        rows.insert(rows.size(), '{v, 1'b0});
        v = flat_voxel(10, 20, 3, 16'sd5);
        v.corner_0 = -16'sd7;
        rows.insert(rows.size(), '{v, 1'b0});
        v = flat_voxel(0, 0, 0, 16'sd1);
        v.corner_3 = -16'sd1;
        rows.insert(rows.size(), '{v, 1'b0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cfg_write(snm_pkg::CFG_ORIGIN_X, 32'h0);
        cfg_write(snm_pkg::CFG_ORIGIN_Y, 32'h0);
        cfg_write(snm_pkg::CFG_ORIGIN_Z, 32'h0);
        cfg_write(snm_pkg::CFG_CELL, 32'h0001_0000);
        foreach (rows[i]) send(rows[i].v, rows[i].quiet);
        random_phase(RANDOM_ITEMS / 4);
        settle();

        cfg_write(snm_pkg::CFG_ORIGIN_X, 32'h7FFF_FFFF);
        cfg_write(snm_pkg::CFG_ORIGIN_Y, 32'h8000_0000);
        cfg_write(snm_pkg::CFG_ORIGIN_Z, $urandom);
        cfg_write(snm_pkg::CFG_CELL, 32'hFFFF_FFFF);
        random_phase(RANDOM_ITEMS / 4);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_records.size() != 0);
        random_phase(RANDOM_ITEMS / 8);
        settle();

        cfg_write(snm_pkg::CFG_ORIGIN_X, $urandom);
        cfg_write(snm_pkg::CFG_ORIGIN_Y, $urandom);
        cfg_write(snm_pkg::CFG_CELL, 32'h0);
        random_phase(RANDOM_ITEMS / 8);
        settle();

        cfg_write(snm_pkg::CFG_ORIGIN_X, $urandom);
        cfg_write(snm_pkg::CFG_ORIGIN_Y, $urandom);
        cfg_write(snm_pkg::CFG_ORIGIN_Z, $urandom);
        cfg_write(snm_pkg::CFG_CELL, $urandom_range(1, 32'h0004_0000));
        random_phase(RANDOM_ITEMS / 4);
        settle();

        if (pending_records.size() != 0) note_mismatch("records never arrived");
        if (err_cnt == 0) begin
            $display("surface_nets_voxel_mesher_top test passed");
        end else begin
            $display("surface_nets_voxel_mesher_top test failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/snm_pkg.sv
rtl/snm_ram.sv
rtl/surface_nets_voxel_mesher_top.sv
sim/surface_nets_voxel_mesher_top_test.sv
